// ===== rtl/gdad_pkg.sv =====
// gdad_pkg: shared widths, constants and month length table for the date adder
package gdad_pkg;

  // field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ADD_W   = 15;
  localparam int ACC_W   = 16;
  localparam int C100_W  = 7;
  localparam int CENT_W  = 2;

  // packed stream widths
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 24;

  // month codes and calendar constants
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [ACC_W-1:0]   FOUR_CENTURIES = 16'd400;
  localparam logic [ACC_W-1:0]   ONE_CENTURY    = 16'd100;
  localparam logic [C100_W-1:0]  LAST_IN_CENTURY = 7'd99;
  localparam logic [YEAR_W-1:0]  YEAR_MAX = {YEAR_W{1'b1}};

  // days in month m, zero for codes that are no month
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/gregorian_date_add_days_unit.sv =====
// gregorian_date_add_days_unit: adds a day count to a Gregorian date, one month per cycle
//
// Input stream (s_*): one transaction carries start day, month, year and the number of
// days to add. Output stream (m_*): one transaction per input with the resulting date.
// The block holds one date at a time; s_tready is high only while the sequencer is idle.
// Steps, in order: year mod 400 by subtracting 400 repeatedly, the century digit by
//   subtracting 100, the sum of day and count, the day-of-year over the months before
//   the start month, the month walk, and the result load.
// The month walk dominates: one shared adder/subtractor takes one month length per
// cycle. The same unit does every step.
// Leap years come from a year-within-century counter and a century counter mod 4,
// seeded by repeated subtraction and stepped as the walk crosses into a new year.
// The result sits in an output register; a new input is taken while it waits.
// If the receiver stalls with a result still waiting, the next finished result holds
// the sequencer until the register frees up; nothing is dropped.
// Reset (rst, synchronous) returns the sequencer to idle and clears m_tvalid.
module gregorian_date_add_days_unit
  import gdad_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata: start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[37:23]
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata: result_day[4:0], result_month[8:5], result_year[22:9]
  output logic [M_DATA_W-1:0] m_tdata
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MOD400 = 6'b000010,
    ST_MOD100 = 6'b000100,
    ST_LOAD   = 6'b001000,
    ST_DOY    = 6'b010000,
    ST_WALK   = 6'b100000
  } state_t;

  state_t              state;
  logic [ACC_W-1:0]    acc;
  logic [DAY_W-1:0]    day;
  logic [MONTH_W-1:0]  month;
  logic [YEAR_W-1:0]   year;
  logic [ADD_W-1:0]    add;
  logic [MONTH_W-1:0]  m;
  logic [C100_W-1:0]   c100;
  logic [CENT_W-1:0]   cent;

  logic [DAY_W-1:0]    res_day;
  logic [MONTH_W-1:0]  res_month;
  logic [YEAR_W-1:0]   res_year;

  logic                leap;
  logic [DAY_W-1:0]    len;
  logic [ACC_W-1:0]    alu_a;
  logic [ACC_W-1:0]    alu_b;
  logic                alu_sub;
  logic [ACC_W:0]      alu_res;
  logic                borrow;
  logic                walk_more;
  logic                out_free;
  logic                finish;
  logic                in_xact;

  // handshake
  assign s_tready = (state == ST_IDLE) && !rst;
  assign in_xact  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // leap rule from year-within-century and century mod 4
  assign leap = ((c100[1:0] == 2'd0) && (c100 != '0)) || ((c100 == '0) && (cent == '0));
  assign len  = month_days(m, leap);

  // shared adder/subtractor operand selection
  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_MOD400: begin
        alu_b   = FOUR_CENTURIES;
        alu_sub = 1'b1;
      end
      ST_MOD100: begin
        alu_b   = ONE_CENTURY;
        alu_sub = 1'b1;
      end
      ST_LOAD: begin
        alu_a = {{(ACC_W-ADD_W){1'b0}}, add};
        alu_b = {{(ACC_W-DAY_W){1'b0}}, day};
      end
      ST_DOY: begin
        alu_b = {{(ACC_W-DAY_W){1'b0}}, len};
      end
      ST_WALK: begin
        alu_b   = {{(ACC_W-DAY_W){1'b0}}, len};
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_res   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow    = alu_res[ACC_W];
  assign walk_more = !borrow && (alu_res[ACC_W-1:0] != '0);
  assign finish    = (state == ST_WALK) && !walk_more && out_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xact) begin
            state <= ST_MOD400;
          end
        end
        ST_MOD400: begin
          if (borrow) begin
            state <= ST_MOD100;
          end
        end
        ST_MOD100: begin
          if (borrow) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_DOY;
        end
        ST_DOY: begin
          if (!((m < month) && (m <= MONTH_DEC))) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xact) begin
          day   <= s_tdata[4:0];
          month <= s_tdata[8:5];
          year  <= s_tdata[22:9];
          add   <= s_tdata[37:23];
          acc   <= {{(ACC_W-YEAR_W){1'b0}}, s_tdata[22:9]};
          cent  <= '0;
        end
      end
      ST_MOD400: begin
        if (!borrow) begin
          acc <= alu_res[ACC_W-1:0];
        end
      end
      ST_MOD100: begin
        if (!borrow) begin
          acc  <= alu_res[ACC_W-1:0];
          cent <= cent + 1'b1;
        end else begin
          c100 <= acc[C100_W-1:0];
        end
      end
      ST_LOAD: begin
        acc <= alu_res[ACC_W-1:0];
        m   <= MONTH_JAN;
      end
      ST_DOY: begin
        if ((m < month) && (m <= MONTH_DEC)) begin
          acc <= alu_res[ACC_W-1:0];
          m   <= m + 1'b1;
        end else begin
          m <= MONTH_JAN;
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          acc <= alu_res[ACC_W-1:0];
          if (m == MONTH_DEC) begin
            m <= MONTH_JAN;
            // new year: wrap of the year field restarts the leap counters at year zero
            if (year == YEAR_MAX) begin
              year <= '0;
              c100 <= '0;
              cent <= '0;
            end else begin
              year <= year + 1'b1;
              if (c100 == LAST_IN_CENTURY) begin
                c100 <= '0;
                cent <= cent + 1'b1;
              end else begin
                c100 <= c100 + 1'b1;
              end
            end
          end else begin
            m <= m + 1'b1;
          end
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (finish) begin
      res_day   <= acc[DAY_W-1:0];
      res_month <= m;
      res_year  <= year;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(M_DATA_W-DAY_W-MONTH_W-YEAR_W){1'b0}}, res_year, res_month, res_day};

endmodule

// ===== rtl/gdad_checker.sv =====
// gdad_checker: port-level checks for the date adder, bound to the top level
module gdad_checker
  import gdad_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one date in flight: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // resulting month is a real month
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:5] >= MONTH_JAN) && (m_tdata[8:5] <= MONTH_DEC))
    else $error("result month out of range");

  // day zero can only come out in january
  a_day_zero_jan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:0] == '0) |-> (m_tdata[8:5] == MONTH_JAN))
    else $error("day zero outside january");

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (.*);

// ===== test/testbench.sv =====
// testbench: directed and randomized stream check of the gregorian date adder against a built-in predictor
module testbench;
  import gdad_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_CYCLES  = 2500;   // long output hold-off
  localparam int TAIL_CYCLES  = 1300;   // tail wait, longer than the worst-case latency of one item
  localparam int STALL_LIMIT  = 20000;  // several times a long hold-off plus a full walk

  // one start date with its count, plus a flag that holds the sender until the pipe drains
  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [ADD_W-1:0]   add;
    bit                 drain_first;
  } date_req_t;

  // packed from the top bit down, so day lands in the low bits as on m_tdata
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct {
    date_req_t start;
    date_t     want;
  } date_check_t;

  typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  date_req_t   pending_dates[$];
  date_check_t expected_dates[$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned directed_cnt = 0;
  int unsigned odd_field_cnt = 0;
  int unsigned long_add_cnt = 0;
  int unsigned drain_cnt = 0;
  int unsigned hold_cnt = 0;

  // sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned phase_left = 0;
  logic [15:0] stall_bits = 16'hffff;
  rx_mode_t    rx_mode = RX_OPEN;

  gregorian_date_add_days_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // gregorian leap rule
  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // length of month m in year y, zero for codes that are no month
  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // day-of-year of the start, plus the count, walked month by month from january
  function automatic date_t add_days_to_date(input date_req_t req);
    date_t       res;
    int unsigned rem;
    int unsigned mon;
    int unsigned yr;
    rem = req.day;
    yr  = req.year;
    for (mon = 1; mon < req.month && mon <= 12; mon++)
      rem += month_length(mon, yr);
    rem += req.add;
    mon = 1;
    while (rem > month_length(mon, yr)) begin
      rem -= month_length(mon, yr);
      if (mon == 32'(MONTH_DEC)) begin
        mon = 1;
        yr  = (yr + 1) & 32'(YEAR_MAX);
      end else begin
        mon++;
      end
    end
    res.day   = DAY_W'(rem);
    res.month = MONTH_W'(mon);
    res.year  = YEAR_W'(yr);
    return res;
  endfunction

  task automatic queue_date(input int unsigned d, input int unsigned m, input int unsigned y,
                            input int unsigned a, input bit drain);
    date_req_t req;
    req.day         = DAY_W'(d);
    req.month       = MONTH_W'(m);
    req.year        = YEAR_W'(y);
    req.add         = ADD_W'(a);
    req.drain_first = drain;
    if (m < 1 || m > 12 || d < 1 || d > month_length(m, y) || y < 1 || y > 9999)
      odd_field_cnt++;
    if (a > 4000)
      long_add_cnt++;
    pending_dates.push_back(req);
  endtask

  task automatic report_date(input string kind, input date_check_t c, input date_t got);
    failures++;
    if (failures <= 10)
      $display("%s: start %0d/%0d/%0d plus %0d, expected %0d/%0d/%0d, got %0d/%0d/%0d",
               kind, c.start.day, c.start.month, c.start.year, c.start.add,
               c.want.day, c.want.month, c.want.year, got.day, got.month, got.year);
  endtask

  // stimulus, reset and end of run
  initial begin
    int unsigned sel;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned a;
    date_check_t none;

    // calendar corners and the odd field values
    queue_date(1, MONTH_JAN, 2023, 0, 1'b0);
    queue_date(31, MONTH_DEC, 1999, 1, 1'b0);
    queue_date(28, MONTH_FEB, 2024, 1, 1'b0);
    queue_date(28, MONTH_FEB, 1900, 1, 1'b0);
    queue_date(28, MONTH_FEB, 2000, 1, 1'b0);
    queue_date(31, MONTH_FEB, 2023, 0, 1'b0);
    queue_date(31, MONTH_FEB, 2024, 0, 1'b0);
    queue_date(0, MONTH_JAN, 2023, 0, 1'b0);
    queue_date(0, 0, 2023, 0, 1'b0);
    queue_date(15, 0, 1987, 10, 1'b0);
    queue_date(5, 13, 2021, 0, 1'b0);
    queue_date(31, 15, 2019, 3, 1'b0);
    queue_date(28, MONTH_FEB, 0, 1, 1'b0);
    queue_date(31, MONTH_DEC, 32'(YEAR_MAX), 1, 1'b0);
    queue_date(1, MONTH_JAN, 32'(YEAR_MAX), 32767, 1'b1);
    queue_date(1, MONTH_JAN, 1, 32767, 1'b0);
    queue_date(31, MONTH_DEC, 9999, 32767, 1'b0);
    queue_date(31, 15, 32'(YEAR_MAX), 32767, 1'b0);
    queue_date(29, MONTH_FEB, 2096, 365, 1'b0);
    queue_date(1, 3, 2100, 0, 1'b0);
    directed_cnt = pending_dates.size();

    // mostly real dates with short counts, some raw field noise and a few huge counts
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 88) begin
        m = $urandom_range(1, 12);
        y = $urandom_range(1, 9999);
        d = $urandom_range(1, month_length(m, y));
      end else begin
        d = $urandom & 32'h1f;
        m = $urandom & 32'hf;
        y = (sel < 94) ? ($urandom & 32'(YEAR_MAX)) : $urandom_range(16200, 32'(YEAR_MAX));
      end
      sel = $urandom_range(0, 99);
      if (sel < 4)
        a = $urandom & 32'h7fff;
      else if (sel < 25)
        a = $urandom_range(0, 4000);
      else if (sel < 75)
        a = $urandom_range(0, 400);
      else
        a = $urandom_range(0, 40);
      queue_date(d, m, y, a, ($urandom_range(0, 63) == 0) || (i == 240));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_dates.size() == 0 && !s_tvalid && items_sent == results_seen))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    while (expected_dates.size() != 0) begin
      none.want = '0;
      report_date("missing result", expected_dates.pop_front(), none.want);
    end

    $display("run covered %0d dates (%0d directed, %0d with off-calendar fields,",
             items_sent, directed_cnt, odd_field_cnt);
    $display("%0d counts over 4000), %0d long output hold-offs, %0d sender pauses until drained",
             long_add_cnt, hold_cnt, drain_cnt);
    if (failures == 0)
      $display("gregorian_date_add_days_unit: match");
    else
      $display("gregorian_date_add_days_unit: mismatch");
    $finish;
  end

  // input driver: bursts of transactions with random gaps, optional drain before an item
  always @(posedge clk) begin
    date_req_t req;
    date_check_t chk;
    bit fire_in;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire_in = s_tvalid && s_tready;
      if (fire_in) begin
        chk.start.day         = s_tdata[4:0];
        chk.start.month       = s_tdata[8:5];
        chk.start.year        = s_tdata[22:9];
        chk.start.add         = s_tdata[37:23];
        chk.start.drain_first = 1'b0;
        chk.want = add_days_to_date(chk.start);
        expected_dates.push_back(chk);
        items_sent <= items_sent + 1;
      end
      if (!s_tvalid || fire_in) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_dates.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_dates[0].drain_first && (fire_in || items_sent != results_seen)) begin
          s_tvalid <= 1'b0;
        end else begin
          req = pending_dates.pop_front();
          if (req.drain_first)
            drain_cnt++;
          s_tdata  <= {2'b00, req.add, req.year, req.month, req.day};
          s_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 :
                         ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // output monitor and receiver stall pattern
  always @(posedge clk) begin
    date_t got;
    date_check_t chk;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[22:0];
        if (results_seen >= items_sent) begin
          chk.start = '{default: '0};
          chk.want  = '0;
          report_date("unexpected result", chk, got);
        end else begin
          chk = expected_dates.pop_front();
          if (got.day !== chk.want.day || got.month !== chk.want.month ||
              got.year !== chk.want.year)
            report_date("date mismatch", chk, got);
          results_seen <= results_seen + 1;
          if (results_seen + 1 == 120 || results_seen + 1 == 330) begin
            hold_left = HOLD_CYCLES;
            hold_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          rx_mode    = rx_mode_t'($urandom_range(0, 2));
          phase_left = $urandom_range(20, 300);
          stall_bits = 16'($urandom);
        end else begin
          phase_left--;
        end
        case (rx_mode)
          RX_OPEN: begin
            m_tready <= 1'b1;
          end
          RX_PATTERN: begin
            m_tready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[15:1]};
          end
          default: begin
            m_tready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d sent, %0d received",
               STALL_LIMIT, items_sent, results_seen);
      $display("gregorian_date_add_days_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/gdad_pkg.sv
rtl/gregorian_date_add_days_unit.sv
rtl/gdad_checker.sv
test/testbench.sv
